// ===== sv/ratacc_pkg.sv =====
package ratacc_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    localparam logic ALU_MUL = 1'b0;
    localparam logic ALU_DIV = 1'b1;

    typedef struct packed {
        logic start;
        logic mode;
    } t_alu_ctl;

endpackage

// ===== sv/rational_accumulator_add_mul_unit.sv =====
// Sequence: an add makes three passes of the shared multiply/divide unit, a multiply one pass
//   fewer; then Euclid remainder steps find the gcd, and two quotient passes divide it out of
//   the numerator and the denominator; a zero gcd skips both quotients.
// Throughput: one item at a time; input stalled from transfer until the cycle after the
//   result load; a stalled result holds the block in its final state.
// Reset: synchronous, active low; accumulator to 0/1, output empty.
module rational_accumulator_add_mul_unit #(
    parameter int WORD_BITS = ratacc_pkg::WORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_opcode,
    input  logic signed [ratacc_pkg::FIELD_BITS-1:0] i_operand_numerator,
    input  logic signed [ratacc_pkg::FIELD_BITS-1:0] i_operand_denominator,
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [ratacc_pkg::FIELD_BITS-1:0] o_result_numerator,
    output logic signed [ratacc_pkg::FIELD_BITS-1:0] o_result_denominator,
    output logic                                     o_zero_divisor_error
);
    import ratacc_pkg::*;

    localparam int EXT = WORD_BITS + FIELD_BITS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULA = 4'd1;
    localparam logic [3:0] S_MULB = 4'd2;
    localparam logic [3:0] S_MULD = 4'd3;
    localparam logic [3:0] S_GCHK = 4'd4;
    localparam logic [3:0] S_GREM = 4'd5;
    localparam logic [3:0] S_DIVN = 4'd6;
    localparam logic [3:0] S_DIVD = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    function automatic logic [WORD_BITS-1:0] f_mag(input logic [WORD_BITS-1:0] v);
        return v[WORD_BITS-1] ? -v : v;
    endfunction

    logic [3:0]           r_state, n_state;
    logic                 r_go, n_go;
    logic                 r_op, n_op;
    logic                 r_err, n_err;
    logic [WORD_BITS-1:0] r_n2, n_n2, r_d2, n_d2, r_t, n_t;
    logic [WORD_BITS-1:0] r_num, n_num, r_den, n_den;
    logic [WORD_BITS-1:0] r_ga, n_ga, r_gb, n_gb;
    logic [WORD_BITS-1:0] r_acc_n, n_acc_n, r_acc_d, n_acc_d;
    logic                 r_out_valid, n_out_valid, r_out_err, n_out_err;
    logic [FIELD_BITS-1:0] r_out_n, n_out_n, r_out_d, n_out_d;

    logic [EXT-1:0]       in_n_ext, in_d_ext, acc_n_ext, acc_d_ext;
    logic                 alu_mode, alu_done;
    logic [WORD_BITS-1:0] alu_a, alu_b, alu_res, alu_rem, div_dvd;
    t_alu_ctl             alu_ctl;

    assign in_n_ext  = {{WORD_BITS{i_operand_numerator[FIELD_BITS-1]}}, i_operand_numerator};
    assign in_d_ext  = {{WORD_BITS{i_operand_denominator[FIELD_BITS-1]}},
                        i_operand_denominator};
    assign acc_n_ext = {{FIELD_BITS{1'b0}}, r_acc_n};
    assign acc_d_ext = {{FIELD_BITS{1'b0}}, r_acc_d};

    assign div_dvd = (r_state == S_DIVD) ? r_den : r_num;

    always_comb begin
        alu_mode = ALU_DIV;
        alu_a    = '0;
        alu_b    = '0;
        unique case (r_state)
            S_MULA: begin
                alu_mode = ALU_MUL;
                alu_a    = r_acc_n;
                alu_b    = (r_op == OP_ADD) ? r_d2 : r_n2;
            end
            S_MULB: begin
                alu_mode = ALU_MUL;
                alu_a    = r_acc_d;
                alu_b    = r_n2;
            end
            S_MULD: begin
                alu_mode = ALU_MUL;
                alu_a    = r_acc_d;
                alu_b    = r_d2;
            end
            S_GREM: begin
                alu_a = f_mag(r_ga);
                alu_b = f_mag(r_gb);
            end
            S_DIVN, S_DIVD: begin
                alu_a = f_mag(div_dvd);
                alu_b = f_mag(r_ga);
            end
            default: ;
        endcase
    end

    assign alu_ctl.start = r_go;
    assign alu_ctl.mode  = alu_mode;

    ratacc_alu #(
        .WORD_BITS (WORD_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res),
        .o_rem   (alu_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_go        = 1'b0;
        n_op        = r_op;
        n_err       = r_err;
        n_n2        = r_n2;
        n_d2        = r_d2;
        n_t         = r_t;
        n_num       = r_num;
        n_den       = r_den;
        n_ga        = r_ga;
        n_gb        = r_gb;
        n_acc_n     = r_acc_n;
        n_acc_d     = r_acc_d;
        n_out_valid = r_out_valid;
        n_out_err   = r_out_err;
        n_out_n     = r_out_n;
        n_out_d     = r_out_d;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_opcode;
                    n_n2    = in_n_ext[WORD_BITS-1:0];
                    n_d2    = in_d_ext[WORD_BITS-1:0];
                    n_err   = 1'b0;
                    n_go    = 1'b1;
                    n_state = S_MULA;
                end
            end
            S_MULA: begin
                if (alu_done) begin
                    n_t     = alu_res;
                    n_go    = 1'b1;
                    n_state = (r_op == OP_ADD) ? S_MULB : S_MULD;
                end
            end
            S_MULB: begin
                if (alu_done) begin
                    n_t     = r_t + alu_res;
                    n_go    = 1'b1;
                    n_state = S_MULD;
                end
            end
            S_MULD: begin
                if (alu_done) begin
                    n_num   = r_t;
                    n_den   = alu_res;
                    n_ga    = r_t;
                    n_gb    = alu_res;
                    n_state = S_GCHK;
                end
            end
            S_GCHK: begin
                if (r_gb != '0) begin
                    n_go    = 1'b1;
                    n_state = S_GREM;
                end else if (r_ga == '0) begin
                    n_err   = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_go    = 1'b1;
                    n_state = S_DIVN;
                end
            end
            S_GREM: begin
                if (alu_done) begin
                    n_ga    = r_gb;
                    n_gb    = r_ga[WORD_BITS-1] ? -alu_rem : alu_rem;
                    n_state = S_GCHK;
                end
            end
            S_DIVN: begin
                if (alu_done) begin
                    n_acc_n = (r_num[WORD_BITS-1] ^ r_ga[WORD_BITS-1]) ? -alu_res : alu_res;
                    n_go    = 1'b1;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (alu_done) begin
                    n_acc_d = (r_den[WORD_BITS-1] ^ r_ga[WORD_BITS-1]) ? -alu_res : alu_res;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_n     = acc_n_ext[FIELD_BITS-1:0];
                    n_out_d     = acc_d_ext[FIELD_BITS-1:0];
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_acc_n     <= '0;
            r_acc_d     <= {{(WORD_BITS-1){1'b0}}, 1'b1};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_acc_n     <= n_acc_n;
            r_acc_d     <= n_acc_d;
            r_out_valid <= n_out_valid;
        end
        r_op      <= n_op;
        r_err     <= n_err;
        r_n2      <= n_n2;
        r_d2      <= n_d2;
        r_t       <= n_t;
        r_num     <= n_num;
        r_den     <= n_den;
        r_ga      <= n_ga;
        r_gb      <= n_gb;
        r_out_err <= n_out_err;
        r_out_n   <= n_out_n;
        r_out_d   <= n_out_d;
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_result_numerator   = r_out_n;
    assign o_result_denominator = r_out_d;
    assign o_zero_divisor_error = r_out_err;

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && n_out_valid && !r_out_valid |-> r_state == S_FIN)
        else $error("result loaded outside final state");

    a_alu_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state != S_IDLE && r_state != S_GCHK && r_state != S_FIN))
        else $error("unit finished with no operation pending");

    a_acc_den_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_acc_d) |-> $past(r_state) == S_DIVD)
        else $error("accumulator denominator changed outside reduction");

endmodule

// ===== sv/ratacc_alu.sv =====
module ratacc_alu #(
    parameter int WORD_BITS = ratacc_pkg::WORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ratacc_pkg::t_alu_ctl  i_ctl,
    input  logic [WORD_BITS-1:0]  i_a,
    input  logic [WORD_BITS-1:0]  i_b,
    output logic                  o_done,
    output logic [WORD_BITS-1:0]  o_res,
    output logic [WORD_BITS-1:0]  o_rem
);
    import ratacc_pkg::*;

    localparam int CW = $clog2(WORD_BITS);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic                 r_mode, n_mode;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_sh, n_sh;
    logic [WORD_BITS-1:0] r_a, n_a;

    logic [WORD_BITS:0]   base, addend, sum;

    // one shared adder: shift-add multiply or restoring divide step
    always_comb begin
        if (r_mode == ALU_DIV) begin
            base   = {r_acc, r_sh[WORD_BITS-1]};
            addend = ~{1'b0, r_a};
        end else begin
            base   = {r_acc, 1'b0};
            addend = r_sh[WORD_BITS-1] ? {1'b0, r_a} : '0;
        end
        sum = base + addend + {{WORD_BITS{1'b0}}, (r_mode == ALU_DIV)};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_sh   = r_sh;
        n_a    = r_a;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_mode = i_ctl.mode;
            n_cnt  = CW'(WORD_BITS - 1);
            n_acc  = '0;
            n_sh   = (i_ctl.mode == ALU_DIV) ? i_a : i_b;
            n_a    = (i_ctl.mode == ALU_DIV) ? i_b : i_a;
        end else if (r_busy) begin
            if (r_mode == ALU_DIV) begin
                n_acc = sum[WORD_BITS] ? base[WORD_BITS-1:0] : sum[WORD_BITS-1:0];
                n_sh  = {r_sh[WORD_BITS-2:0], ~sum[WORD_BITS]};
            end else begin
                n_acc = sum[WORD_BITS-1:0];
                n_sh  = {r_sh[WORD_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_mode <= n_mode;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_sh   <= n_sh;
        r_a    <= n_a;
    end

    assign o_done = r_done;
    assign o_res  = (r_mode == ALU_DIV) ? r_sh : r_acc;
    assign o_rem  = r_acc;

endmodule
